/* rtl/core/stks_pkg.sv */
// Shared types and constants for the streaming top-k selector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package stks_pkg;

	localparam int MAX_KEEP    = 16;
	localparam int INDEX_WIDTH = 24;
	localparam int SCORE_WIDTH = 32;
	localparam int RANK_WIDTH  = 4;
	localparam int KEEP_WIDTH  = 5;
	localparam int CNT_WIDTH   = $clog2(MAX_KEEP + 1);

	localparam logic [KEEP_WIDTH-1:0] KEEP_RESET = KEEP_WIDTH'(5);

	typedef struct packed {
		logic [SCORE_WIDTH-1:0] candidate_score;
		logic [INDEX_WIDTH-1:0] candidate_index;
		logic                   end_of_set;
	} cand_t;

	typedef struct packed {
		logic [SCORE_WIDTH-1:0] result_score;
		logic [INDEX_WIDTH-1:0] result_index;
		logic [RANK_WIDTH-1:0]  result_rank;
		logic                   last_result;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic insert;
		logic load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_entry;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/stks_ctrl.sv */
// Controller for the top-k selector: accept candidates, then sequence emission.
// Depends on stks_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module stks_ctrl
	import stks_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    end_of_set,
	output logic         in_stall,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_EMIT    = 1'b1;

	logic state_q;
	logic state_d;

	assign in_stall = (state_q == ST_EMIT);

	always_comb begin
		state_d    = state_q;
		cmd.insert = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				cmd.insert = in_valid;
				if (in_valid && end_of_set) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.load = sts.out_free;
				if (sts.out_free && sts.last_entry) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/stks_datapath.sv */
// Datapath for the top-k selector: keep-count register, sorted compare-and-shift
// row, live count, rank counter and output register. Depends on stks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stks_datapath
	import stks_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [KEEP_WIDTH-1:0] cfg_data,
	input  wire cand_t                 cand,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output result_t                    out_data
);

	logic [KEEP_WIDTH-1:0]  keep_q;
	logic [CNT_WIDTH-1:0]   keep_eff;
	logic [CNT_WIDTH-1:0]   live_q;
	logic [CNT_WIDTH-1:0]   live_eff;
	logic [CNT_WIDTH-1:0]   live_ins;
	logic [RANK_WIDTH-1:0]  rank_q;
	logic [SCORE_WIDTH-1:0] score_q [MAX_KEEP];
	logic [INDEX_WIDTH-1:0] index_q [MAX_KEEP];
	logic [MAX_KEEP-1:0]    wins;
	logic                   out_valid_q;
	result_t                out_q;

	function automatic logic beats(input logic [SCORE_WIDTH-1:0] sa,
			input logic [INDEX_WIDTH-1:0] ia, input logic [SCORE_WIDTH-1:0] sb,
			input logic [INDEX_WIDTH-1:0] ib);
		beats = (sa < sb) || ((sa == sb) && (ia < ib));
	endfunction

	// clamp keep count into 1..MAX_KEEP
	always_comb begin
		if (keep_q == '0) begin
			keep_eff = CNT_WIDTH'(1);
		end else if (32'(keep_q) > MAX_KEEP) begin
			keep_eff = CNT_WIDTH'(MAX_KEEP);
		end else begin
			keep_eff = CNT_WIDTH'(keep_q);
		end
	end

	assign live_eff = (live_q > keep_eff) ? keep_eff : live_q;
	assign live_ins = (live_eff < keep_eff) ? live_eff + CNT_WIDTH'(1) : live_eff;

	// slots past the live end count as beaten, so the win vector is a thermometer
	always_comb begin
		for (int i = 0; i < MAX_KEEP; i++) begin
			wins[i] = (CNT_WIDTH'(i) >= live_eff) ||
				beats(cand.candidate_score, cand.candidate_index, score_q[i], index_q[i]);
		end
	end

	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.last_entry = (live_q == CNT_WIDTH'(1));

	// list row: insert by shift on a candidate, shift towards the head on emission
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (wins[0]) begin
				score_q[0] <= cand.candidate_score;
				index_q[0] <= cand.candidate_index;
			end
			for (int i = 1; i < MAX_KEEP; i++) begin
				if (wins[i-1]) begin
					score_q[i] <= score_q[i-1];
					index_q[i] <= index_q[i-1];
				end else if (wins[i]) begin
					score_q[i] <= cand.candidate_score;
					index_q[i] <= cand.candidate_index;
				end
			end
		end else if (cmd.load) begin
			for (int i = 0; i < MAX_KEEP - 1; i++) begin
				score_q[i] <= score_q[i+1];
				index_q[i] <= index_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.result_score <= score_q[0];
			out_q.result_index <= index_q[0];
			out_q.result_rank  <= rank_q;
			out_q.last_result  <= sts.last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q      <= KEEP_RESET;
			live_q      <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_data;
			end
			if (cmd.insert) begin
				live_q <= live_ins;
			end else if (cmd.load) begin
				live_q <= live_q - CNT_WIDTH'(1);
			end
			if (cmd.load) begin
				rank_q <= sts.last_entry ? '0 : rank_q + RANK_WIDTH'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* rtl/core/streaming_top_k_selector.sv */
// Streaming top-k selector: one candidate transaction per cycle while collecting.
// After the end-of-set transaction the list row drains through the output register,
// one result per cycle without output stall; input stalls while the emission
// sequencer drains the list row.
// Reset (arst_n, asynchronous): empty list, keep_count 5, no result pending.
// Depends on stks_pkg, stks_ctrl and stks_datapath.
`timescale 1ns / 1ps
`default_nettype none

module streaming_top_k_selector
	import stks_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration: keep_count, written whenever cfg_we is high
	input  wire logic                  cfg_we,
	input  wire logic [KEEP_WIDTH-1:0] cfg_data,
	// candidate channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire cand_t                 in_data,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output result_t                    out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller: take candidates while collecting; after the end of a set,
	// advance one list entry into the output register each time it frees up,
	// and hold the input until the final entry has been loaded.
	stks_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.end_of_set (in_data.end_of_set),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Datapath: the sorted row inserts a candidate by
	// comparing it against every entry in parallel and shifting worse entries
	// down; entries falling off the end drop. Emission shifts the row towards
	// the head, so the best remaining entry always sits in slot zero.
	stks_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cand      (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sim/streaming_top_k_selector_tb.sv */
// Self-checking testbench for streaming_top_k_selector: named tests drive candidate sets,
// a running model of the best-first list predicts every emitted result.
// Depends on stks_pkg and the streaming_top_k_selector RTL only.
`timescale 1ns / 1ps

module streaming_top_k_selector_tb;
	import stks_pkg::*;

	localparam int SETTLE_CYCLES = 16;   // idle margin after the last owed result
	localparam int LONG_HOLD     = 300;  // receiver hold-off in the backpressure test
	localparam int MAX_REPORTS   = 10;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [KEEP_WIDTH-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	cand_t                 in_data  = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	result_t               out_data;

	// Model of the kept list, updated as each candidate transaction is accepted
	logic [SCORE_WIDTH-1:0] best_scores  [MAX_KEEP];
	logic [INDEX_WIDTH-1:0] best_indices [MAX_KEEP];
	int                     live_entries = 0;
	logic [KEEP_WIDTH-1:0]  keep_setting = KEEP_RESET;

	// Emitted entries still owed by the block, oldest first
	result_t pending_results[$];

	int  error_count     = 0;
	int  cands_sent      = 0;
	int  sets_closed     = 0;
	int  results_checked = 0;
	bit  idling_on       = 1'b1;
	bit  long_hold_req   = 1'b0;

	streaming_top_k_selector u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// List model
	// ------------------------------------------------------------------

	// Lower score wins; equal scores fall back to the lower library index
	function automatic bit outranks(logic [SCORE_WIDTH-1:0] sa, logic [INDEX_WIDTH-1:0] ia,
			logic [SCORE_WIDTH-1:0] sb, logic [INDEX_WIDTH-1:0] ib);
		return (sa < sb) || (sa == sb && ia < ib);
	endfunction

	// Zero behaves as one, anything past the row length as the full row
	function automatic int effective_keep();
		if (keep_setting == 0)
			return 1;
		if (keep_setting > MAX_KEEP)
			return MAX_KEEP;
		return int'(keep_setting);
	endfunction

	// Offer one candidate to the list; on end of set queue the whole list best first
	function automatic void track_candidate(cand_t c);
		int      lim;
		int      pos;
		result_t r;
		lim = effective_keep();
		// a lowered keep count trims the worst entries before anything else
		if (live_entries > lim)
			live_entries = lim;
		if (!(live_entries == lim &&
				!outranks(c.candidate_score, c.candidate_index,
					best_scores[lim-1], best_indices[lim-1]))) begin
			if (live_entries < lim) begin
				pos = live_entries;
				live_entries++;
			end else begin
				pos = lim - 1;
			end
			// shift worse entries down one place to open the slot
			while (pos > 0 && outranks(c.candidate_score, c.candidate_index,
					best_scores[pos-1], best_indices[pos-1])) begin
				best_scores[pos]  = best_scores[pos-1];
				best_indices[pos] = best_indices[pos-1];
				pos--;
			end
			best_scores[pos]  = c.candidate_score;
			best_indices[pos] = c.candidate_index;
		end
		if (c.end_of_set) begin
			for (int k = 0; k < live_entries; k++) begin
				r.result_score = best_scores[k];
				r.result_index = best_indices[k];
				r.result_rank  = RANK_WIDTH'(k);
				r.last_result  = (k == live_entries - 1);
				pending_results = {pending_results, r};
			end
			live_entries = 0;
			sets_closed++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall generator and checker
	// ------------------------------------------------------------------

	// Stall in random bursts while idling is on; a long hold-off on request, counted here
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void report_result_error(string why, result_t want, result_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display({"[%0t] %s: expected score %h index %h rank %0d last %0b, ",
				"got score %h index %h rank %0d last %0b"},
				$realtime, why, want.result_score, want.result_index, want.result_rank,
				want.last_result, got.result_score, got.result_index, got.result_rank,
				got.last_result);
	endfunction

	// Compare every accepted result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_result_error("result with nothing expected", '0, out_data);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (out_data.result_score !== want.result_score ||
						out_data.result_index !== want.result_index ||
						out_data.result_rank !== want.result_rank ||
						out_data.last_result !== want.last_result)
					report_result_error("result mismatch", want, out_data);
			end
		end
	end

	// ------------------------------------------------------------------
	// Candidate side
	// ------------------------------------------------------------------

	// Offer one candidate transaction, with an optional idle burst ahead of it
	task automatic send_candidate(input logic [SCORE_WIDTH-1:0] score,
			input logic [INDEX_WIDTH-1:0] idx, input bit last);
		cand_t c;
		c.candidate_score = score;
		c.candidate_index = idx;
		c.end_of_set      = last;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do
			@(posedge clk);
		while (in_stall);
		track_candidate(c);
		cands_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write keep_count; only called once the block is idle
	task automatic set_keep(input logic [KEEP_WIDTH-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		keep_setting = value;
		cfg_we <= 1'b0;
	endtask

	// Scores lean towards a tiny range so that ties on score turn up often
	function automatic logic [SCORE_WIDTH-1:0] pick_score();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return SCORE_WIDTH'($urandom_range(0, 7));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [INDEX_WIDTH-1:0] pick_index();
		case ($urandom_range(0, 9))
			0:          return '0;
			1:          return '1;
			2, 3, 4, 5: return INDEX_WIDTH'($urandom_range(0, 7));
			default:    return INDEX_WIDTH'($urandom());
		endcase
	endfunction

	// Well-formed sets of random length and content under one keep setting
	task automatic run_random_phase(input logic [KEEP_WIDTH-1:0] keep_value,
			input int n_items);
		int left;
		int set_len;
		wait_idle();
		set_keep(keep_value);
		left = n_items;
		while (left > 0) begin
			set_len = $urandom_range(1, 2 * effective_keep() + 3);
			if (set_len > left)
				set_len = left;
			for (int j = 0; j < set_len; j++)
				send_candidate(pick_score(), pick_index(), j == set_len - 1);
			left -= set_len;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset keep count of five: extreme fields, score ties, a duplicate, a one-item set
	task automatic test_extremes_at_reset_keep();
		send_candidate('1, '1, 1'b0);
		send_candidate('0, '0, 1'b0);
		send_candidate('0, '1, 1'b0);
		send_candidate(32'd7, 24'd5, 1'b0);
		send_candidate(32'd7, 24'd3, 1'b0);
		send_candidate(32'd7, 24'd3, 1'b0);
		send_candidate('1, '0, 1'b0);
		send_candidate(32'd1, 24'd1, 1'b1);
		send_candidate(32'h8000_0000, 24'h80_0000, 1'b1);
		wait_idle();
	endtask

	// Keep count zero acts as one
	task automatic test_keep_zero();
		set_keep('0);
		send_candidate(32'd50, 24'd2, 1'b0);
		send_candidate(32'd20, 24'd9, 1'b0);
		send_candidate(32'd20, 24'd4, 1'b1);
		wait_idle();
	endtask

	// Lower keep count part way through a set: the worst entries drop out
	task automatic test_keep_cut_mid_set();
		set_keep(KEEP_WIDTH'(MAX_KEEP));
		send_candidate(32'd600, 24'd6, 1'b0);
		send_candidate(32'd100, 24'd1, 1'b0);
		send_candidate(32'd500, 24'd5, 1'b0);
		send_candidate(32'd300, 24'd3, 1'b0);
		send_candidate(32'd200, 24'd2, 1'b0);
		send_candidate(32'd400, 24'd4, 1'b0);
		wait_idle();
		set_keep(KEEP_WIDTH'(2));
		send_candidate(32'd250, 24'd7, 1'b1);
		wait_idle();
	endtask

	// Random sets under idling on both sides, keep settings across the range
	task automatic test_random_with_idling();
		idling_on = 1'b1;
		run_random_phase(KEEP_WIDTH'(31), 20);
		run_random_phase(KEEP_WIDTH'(MAX_KEEP), 20);
		run_random_phase(KEEP_WIDTH'(1), 14);
		run_random_phase(KEEP_WIDTH'(3), 14);
		run_random_phase(KEEP_WIDTH'($urandom_range(0, 31)), 16);
		wait_idle();
	endtask

	// Hold the result side off while full sets keep coming, so the input backs up
	task automatic test_output_backpressure();
		idling_on = 1'b0;
		wait_idle();
		set_keep(KEEP_WIDTH'(MAX_KEEP));
		long_hold_req = 1'b1;
		for (int s = 0; s < 2; s++)
			for (int j = 0; j < 20; j++)
				send_candidate(pick_score(), pick_index(), j == 19);
		wait_idle();
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_random_full_rate();
		idling_on = 1'b0;
		run_random_phase(KEEP_WIDTH'(17), 20);
		run_random_phase(KEEP_WIDTH'(2), 20);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : main_sequence
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes_at_reset_keep();
		test_keep_zero();
		test_keep_cut_mid_set();
		test_random_with_idling();
		test_output_backpressure();
		test_random_full_rate();

		// anything still owed at this point is a failure
		if (pending_results.size() != 0) begin
			error_count += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Covered %0d candidates in %0d sets, %0d results checked,", cands_sent,
			sets_closed, results_checked);
		$display("keep counts 0 to 31, score ties, a mid-set cut and a long output hold-off.");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d results still owed", pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/stks_pkg.sv
rtl/core/stks_ctrl.sv
rtl/core/stks_datapath.sv
rtl/core/streaming_top_k_selector.sv
sim/streaming_top_k_selector_tb.sv
